FILE: rtl/core/dpcsv_pkg.sv
// Shared types, constants and helper functions for the daily price CSV parser.
// Used by dpcsv_step and daily_price_csv_parser; depends on nothing else.
package dpcsv_pkg;

	typedef enum logic [3:0] {
		PH_HEADER  = 4'd0,
		PH_YEAR    = 4'd1,
		PH_MONTH   = 4'd2,
		PH_DAY     = 4'd3,
		PH_OPEN    = 4'd4,
		PH_HIGH    = 4'd5,
		PH_LOW     = 4'd6,
		PH_CLOSE   = 4'd7,
		PH_ADJ     = 4'd8,
		PH_VOLUME  = 4'd9,
		PH_DONE    = 4'd10,
		PH_FAILED  = 4'd11,
		PH_HTTPERR = 4'd12
	} phase_t;

	localparam int HeaderLen = 41;
	localparam logic [8*HeaderLen-1:0] HeaderText =
		"Date,Open,High,Low,Close,Adj Close,Volume";

	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_COMMA   = 8'h2C;
	localparam logic [7:0] CH_DASH    = 8'h2D;
	localparam logic [7:0] CH_DOT     = 8'h2E;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;

	localparam logic [9:0]  HTTP_OK    = 10'd200;
	localparam logic [14:0] YEAR_BASE  = 15'd1900;
	localparam logic [30:0] YEAR_MAX   = 31'd9999;
	localparam logic [30:0] TWO_DIGIT_MAX = 31'd99;
	localparam logic [30:0] VOLUME_MAX = 31'h7FFF_FFFF;

	typedef struct packed {
		phase_t             phase;
		logic [5:0]         pos;
		logic signed [14:0] year;
		logic signed [7:0]  month;
		logic [6:0]         day;
		logic [30:0]        volume;
	} parse_state_t;

	typedef struct packed {
		logic       char_valid;
		logic [4:0] pos;
		logic [7:0] char_byte;
		logic       field_end;
	} price_info_t;

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= CH_ZERO) && (b <= CH_NINE);
	endfunction

	// Decimal accumulate: acc * 10 + digit, clamped at maxv.
	function automatic logic [30:0] acc_sat(input logic [30:0] acc, input logic [7:0] b,
			input logic [30:0] maxv);
		logic [34:0] v;
		v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {31'd0, b[3:0]};
		return (v > {4'd0, maxv}) ? maxv : v[30:0];
	endfunction

	// Expected header character at a position below HeaderLen.
	function automatic logic [7:0] header_char(input logic [5:0] idx);
		logic [7:0] c;
		c = 8'd0;
		for (int i = 0; i < HeaderLen; i++) begin
			if (idx == 6'(i))
				c = HeaderText[8*(HeaderLen-1-i) +: 8];
		end
		return c;
	endfunction

endpackage

FILE: rtl/core/dpcsv_step.sv
// Next-state and result logic for one byte of the daily price CSV parser.
// Uses dpcsv_pkg for the phase type, state record and character helpers.
module dpcsv_step #(
	parameter int MAX_FIELD_CHARS = 20
) (
	input  dpcsv_pkg::parse_state_t state_cur,
	input  logic [7:0]              data_byte,
	input  logic                    new_response,
	input  logic                    code_ok,
	output dpcsv_pkg::parse_state_t state_nxt,
	output dpcsv_pkg::price_info_t  price
);

	dpcsv_pkg::parse_state_t st;
	logic digit;

	always_comb begin
		st = state_cur;
		if (new_response) begin
			st.phase  = dpcsv_pkg::PH_HEADER;
			st.pos    = 6'd0;
			st.year   = 15'sd0;
			st.month  = 8'sd0;
			st.day    = 7'd0;
			st.volume = 31'd0;
		end
	end

	assign digit = dpcsv_pkg::is_digit(data_byte);

	always_comb begin
		state_nxt = st;
		price = '0;
		if (!code_ok) begin
			state_nxt.phase = dpcsv_pkg::PH_HTTPERR;
		end else begin
			unique case (st.phase)
				dpcsv_pkg::PH_HEADER: begin
					if (st.pos == 6'(dpcsv_pkg::HeaderLen) && data_byte == dpcsv_pkg::CH_NEWLINE)
						state_nxt.phase = dpcsv_pkg::PH_YEAR;
					else if (st.pos < 6'(dpcsv_pkg::HeaderLen) &&
							data_byte == dpcsv_pkg::header_char(st.pos))
						state_nxt.pos = st.pos + 6'd1;
					else
						state_nxt.phase = dpcsv_pkg::PH_FAILED;
				end
				dpcsv_pkg::PH_YEAR: begin
					if (data_byte == dpcsv_pkg::CH_DASH) begin
						state_nxt.year  = st.year - $signed(dpcsv_pkg::YEAR_BASE);
						state_nxt.phase = dpcsv_pkg::PH_MONTH;
					end else if (digit) begin
						state_nxt.year = $signed(15'(dpcsv_pkg::acc_sat(
							31'($unsigned(st.year)), data_byte, dpcsv_pkg::YEAR_MAX)));
					end else begin
						state_nxt.phase = dpcsv_pkg::PH_FAILED;
					end
				end
				dpcsv_pkg::PH_MONTH: begin
					if (data_byte == dpcsv_pkg::CH_DASH) begin
						state_nxt.month = st.month - 8'sd1;
						state_nxt.phase = dpcsv_pkg::PH_DAY;
					end else if (digit) begin
						state_nxt.month = $signed(8'(dpcsv_pkg::acc_sat(
							31'($unsigned(st.month)), data_byte, dpcsv_pkg::TWO_DIGIT_MAX)));
					end else begin
						state_nxt.phase = dpcsv_pkg::PH_FAILED;
					end
				end
				dpcsv_pkg::PH_DAY: begin
					if (data_byte == dpcsv_pkg::CH_COMMA) begin
						state_nxt.phase = dpcsv_pkg::PH_OPEN;
						state_nxt.pos   = 6'd0;
					end else if (digit) begin
						state_nxt.day = 7'(dpcsv_pkg::acc_sat(31'(st.day), data_byte,
							dpcsv_pkg::TWO_DIGIT_MAX));
					end else begin
						state_nxt.phase = dpcsv_pkg::PH_FAILED;
					end
				end
				dpcsv_pkg::PH_OPEN, dpcsv_pkg::PH_HIGH, dpcsv_pkg::PH_LOW,
				dpcsv_pkg::PH_CLOSE: begin
					if (data_byte == dpcsv_pkg::CH_COMMA) begin
						price.field_end = 1'b1;
						price.pos       = st.pos[4:0];
						state_nxt.phase = dpcsv_pkg::phase_t'(st.phase + 4'd1);
						state_nxt.pos   = 6'd0;
					end else if (st.pos < 6'(MAX_FIELD_CHARS) &&
							(data_byte == dpcsv_pkg::CH_DOT || digit)) begin
						price.char_valid = 1'b1;
						price.pos        = st.pos[4:0];
						price.char_byte  = data_byte;
						state_nxt.pos    = st.pos + 6'd1;
					end else begin
						state_nxt.phase = dpcsv_pkg::PH_FAILED;
					end
				end
				dpcsv_pkg::PH_ADJ: begin
					if (data_byte == dpcsv_pkg::CH_COMMA)
						state_nxt.phase = dpcsv_pkg::PH_VOLUME;
				end
				dpcsv_pkg::PH_VOLUME: begin
					if (data_byte == dpcsv_pkg::CH_NEWLINE)
						state_nxt.phase = dpcsv_pkg::PH_DONE;
					else if (digit)
						state_nxt.volume = dpcsv_pkg::acc_sat(st.volume, data_byte,
							dpcsv_pkg::VOLUME_MAX);
					else
						state_nxt.phase = dpcsv_pkg::PH_FAILED;
				end
				default: begin
					// Done, failed and HTTP error hold until a new response.
				end
			endcase
		end
	end

endmodule

FILE: rtl/core/daily_price_csv_parser.sv
// Daily price CSV parser, top level: input register, parse state and result register.
// Depends on dpcsv_pkg and dpcsv_step.
//
// Usage: response body bytes arrive on the s_ stream, one byte per request, with
// s_tuser[0] marking the first byte of a new response (it clears the parse state).
// Each byte yields exactly one result on the m_ stream: the phase after the byte,
// price character and field-end markers, and the date and volume accumulators.
// The response code is written on the cfg channel while the block is idle; any
// value other than 200 drives the HTTP error phase until the code is 200 again and a new response arrives.
// The byte is registered in the input register and its result in the output register,
// which drives m_tvalid; throughput is one byte per cycle while m_tready stays high,
// as the parse step is combinational on the state registers.
// Reset clears the parse state to the header phase and the response code to 200.
// When the receiver stalls, the result waits in the output register and one more
// byte is held in the input register; s_tready then drops until m_tready returns.
module daily_price_csv_parser #(
	parameter int MAX_FIELD_CHARS = 20
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic [0:0]  s_tuser,   // [0] new_response
	output logic        m_tvalid,
	input  logic        m_tready,
	// [3:0] phase, [8:4] price_pos, [16:9] price_char, [31:17] year_since_1900,
	// [39:32] month_index, [46:40] day_of_month, [77:47] volume, [79:78] zero
	output logic [79:0] m_tdata,
	output logic [1:0]  m_tuser,   // [0] price_char_valid, [1] field_end
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [9:0]  cfg_data
);

	logic                    valid_s1;
	logic [7:0]              byte_s1;
	logic                    newresp_s1;
	logic [9:0]              code_q;
	dpcsv_pkg::parse_state_t state_q;
	dpcsv_pkg::parse_state_t state_d;
	dpcsv_pkg::price_info_t  price_d;
	dpcsv_pkg::price_info_t  price_q;
	logic                    out_valid_q;
	logic                    advance;

	assign advance   = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	dpcsv_step #(
		.MAX_FIELD_CHARS(MAX_FIELD_CHARS)
	) u_step (
		.state_cur   (state_q),
		.data_byte   (byte_s1),
		.new_response(newresp_s1),
		.code_ok     (code_q == dpcsv_pkg::HTTP_OK),
		.state_nxt   (state_d),
		.price       (price_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			out_valid_q  <= 1'b0;
			code_q       <= dpcsv_pkg::HTTP_OK;
			state_q.phase  <= dpcsv_pkg::PH_HEADER;
			state_q.pos    <= 6'd0;
			state_q.year   <= 15'sd0;
			state_q.month  <= 8'sd0;
			state_q.day    <= 7'd0;
			state_q.volume <= 31'd0;
		end else begin
			if (cfg_valid)
				code_q <= cfg_data;
			if (s_tvalid && s_tready)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
			if (advance) begin
				state_q     <= state_d;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1    <= s_tdata;
			newresp_s1 <= s_tuser[0];
		end
		if (advance)
			price_q <= price_d;
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = {price_q.field_end, price_q.char_valid};
	assign m_tdata  = {2'b00, state_q.volume, state_q.day, state_q.month, state_q.year,
		price_q.char_byte, price_q.pos, state_q.phase};

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for daily_price_csv_parser: directed rows, then random responses.
// Every accepted byte is run through a local parser model and the result stream is compared.
// Depends on dpcsv_pkg and the parser RTL only.
module testbench;

	localparam int FieldMax   = 20;
	localparam int StallLimit = 2000;
	localparam int ByteTarget = 450;

	typedef struct packed {
		dpcsv_pkg::phase_t  phase;
		logic               char_valid;
		logic [4:0]         pos;
		logic [7:0]         ch;
		logic               field_end;
		logic signed [14:0] year;
		logic signed [7:0]  month;
		logic [6:0]         day;
		logic [30:0]        volume;
	} parse_result_t;

	typedef struct {
		logic [7:0] b;
		logic       fresh;
		int         row;
	} body_byte_t;

	// One directed request group: optional code write, then one raw byte or a text run.
	// Where typed is set, the last byte's phase and accumulators are given by hand.
	typedef struct {
		bit                fresh;
		int                code;
		int                raw;
		string             text;
		bit                typed;
		dpcsv_pkg::phase_t ph;
		int                year;
		int                month;
		int                day;
		longint            vol;
	} plan_row_t;

	plan_row_t plan[20] = '{
		'{1, -1, -1, "D", 1, dpcsv_pkg::PH_HEADER, 0, 0, 0, 0},
		'{0, -1, -1, "ate,Open,High,Low,Close,Adj Close,Volume\n", 1,
			dpcsv_pkg::PH_YEAR, 0, 0, 0, 0},
		'{0, -1, -1, "99999-", 1, dpcsv_pkg::PH_MONTH, 8099, 0, 0, 0},
		'{0, -1, -1, "123-", 1, dpcsv_pkg::PH_DAY, 8099, 98, 0, 0},
		'{0, -1, -1, "0123,", 1, dpcsv_pkg::PH_OPEN, 8099, 98, 99, 0},
		'{0, -1, -1, "01234567890123456789,", 1, dpcsv_pkg::PH_HIGH, 8099, 98, 99, 0},
		'{0, -1, -1, ".,", 0, dpcsv_pkg::PH_HEADER, 0, 0, 0, 0},
		'{0, -1, -1, ",", 1, dpcsv_pkg::PH_CLOSE, 8099, 98, 99, 0},
		'{0, -1, -1, "9.9,", 0, dpcsv_pkg::PH_HEADER, 0, 0, 0, 0},
		'{0, -1, 0, "", 0, dpcsv_pkg::PH_HEADER, 0, 0, 0, 0},
		'{0, -1, -1, "\377\n x,", 1, dpcsv_pkg::PH_VOLUME, 8099, 98, 99, 0},
		'{0, -1, -1, "99999999999", 1, dpcsv_pkg::PH_VOLUME, 8099, 98, 99, 2147483647},
		'{0, -1, -1, "\n", 1, dpcsv_pkg::PH_DONE, 8099, 98, 99, 2147483647},
		'{0, -1, -1, "z", 1, dpcsv_pkg::PH_DONE, 8099, 98, 99, 2147483647},
		'{1, -1, -1, "X", 1, dpcsv_pkg::PH_FAILED, 0, 0, 0, 0},
		'{1, 0, -1, "D", 1, dpcsv_pkg::PH_HTTPERR, 0, 0, 0, 0},
		'{0, 999, -1, "a", 1, dpcsv_pkg::PH_HTTPERR, 0, 0, 0, 0},
		'{0, 16, -1, "q", 1, dpcsv_pkg::PH_HTTPERR, 0, 0, 0, 0},
		'{0, 200, -1, "D", 1, dpcsv_pkg::PH_HTTPERR, 0, 0, 0, 0},
		'{1, -1, -1, "D", 1, dpcsv_pkg::PH_HEADER, 0, 0, 0, 0}
	};

	string hdr_text = "Date,Open,High,Low,Close,Adj Close,Volume";

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;
	logic [0:0]  s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [79:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [9:0]  cfg_data = 10'd0;

	// Local copy of the parser state and the response code register.
	logic [9:0]        st_code = dpcsv_pkg::HTTP_OK;
	dpcsv_pkg::phase_t st_phase = dpcsv_pkg::PH_HEADER;
	int                st_pos, st_year, st_month, st_day;
	longint            st_vol;

	body_byte_t    body_q[$];
	body_byte_t    on_bus;
	parse_result_t due_results[$];
	parse_result_t want, got;
	int            tagged_row = -1;
	int            bytes_queued, bytes_taken, fails, stall_cycles;
	bit            s_took, calm;

	daily_price_csv_parser uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic longint dec_push(longint acc, logic [7:0] b, longint cap);
		longint v;
		v = acc * 10 + longint'(b - 8'h30);
		return (v > cap) ? cap : v;
	endfunction

	function automatic parse_result_t parse_byte(logic [7:0] b, logic fresh);
		parse_result_t r;
		logic          numeral;
		r = '0;
		numeral = (b >= 8'h30) && (b <= 8'h39);
		if (fresh) begin
			st_phase = dpcsv_pkg::PH_HEADER;
			st_pos = 0;
			st_year = 0;
			st_month = 0;
			st_day = 0;
			st_vol = 0;
		end
		if (st_code != dpcsv_pkg::HTTP_OK) begin
			st_phase = dpcsv_pkg::PH_HTTPERR;
		end else begin
			unique case (st_phase)
				dpcsv_pkg::PH_HEADER: begin
					if (st_pos == dpcsv_pkg::HeaderLen && b == dpcsv_pkg::CH_NEWLINE)
						st_phase = dpcsv_pkg::PH_YEAR;
					else if (st_pos < dpcsv_pkg::HeaderLen && b == hdr_text[st_pos])
						st_pos++;
					else
						st_phase = dpcsv_pkg::PH_FAILED;
				end
				dpcsv_pkg::PH_YEAR: begin
					if (b == dpcsv_pkg::CH_DASH) begin
						st_year -= 1900;
						st_phase = dpcsv_pkg::PH_MONTH;
					end else if (numeral) begin
						st_year = int'(dec_push(st_year, b, 9999));
					end else begin
						st_phase = dpcsv_pkg::PH_FAILED;
					end
				end
				dpcsv_pkg::PH_MONTH: begin
					if (b == dpcsv_pkg::CH_DASH) begin
						st_month -= 1;
						st_phase = dpcsv_pkg::PH_DAY;
					end else if (numeral) begin
						st_month = int'(dec_push(st_month, b, 99));
					end else begin
						st_phase = dpcsv_pkg::PH_FAILED;
					end
				end
				dpcsv_pkg::PH_DAY: begin
					if (b == dpcsv_pkg::CH_COMMA) begin
						st_phase = dpcsv_pkg::PH_OPEN;
						st_pos = 0;
					end else if (numeral) begin
						st_day = int'(dec_push(st_day, b, 99));
					end else begin
						st_phase = dpcsv_pkg::PH_FAILED;
					end
				end
				dpcsv_pkg::PH_OPEN, dpcsv_pkg::PH_HIGH, dpcsv_pkg::PH_LOW,
				dpcsv_pkg::PH_CLOSE: begin
					if (b == dpcsv_pkg::CH_COMMA) begin
						r.field_end = 1'b1;
						r.pos = 5'(st_pos);
						st_phase = dpcsv_pkg::phase_t'(st_phase + 1);
						st_pos = 0;
					end else if (st_pos < FieldMax && (b == dpcsv_pkg::CH_DOT || numeral)) begin
						r.char_valid = 1'b1;
						r.pos = 5'(st_pos);
						r.ch = b;
						st_pos++;
					end else begin
						st_phase = dpcsv_pkg::PH_FAILED;
					end
				end
				dpcsv_pkg::PH_ADJ: begin
					if (b == dpcsv_pkg::CH_COMMA)
						st_phase = dpcsv_pkg::PH_VOLUME;
				end
				dpcsv_pkg::PH_VOLUME: begin
					if (b == dpcsv_pkg::CH_NEWLINE)
						st_phase = dpcsv_pkg::PH_DONE;
					else if (numeral)
						st_vol = dec_push(st_vol, b, 64'h7FFF_FFFF);
					else
						st_phase = dpcsv_pkg::PH_FAILED;
				end
				default: ;
			endcase
		end
		r.phase = st_phase;
		r.year = 15'(st_year);
		r.month = 8'(st_month);
		r.day = 7'(st_day);
		r.volume = 31'(st_vol);
		return r;
	endfunction

	function automatic void compare_field(string name, longint exp_val, longint act_val);
		if (exp_val != act_val) begin
			$error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
			fails++;
		end
	endfunction

	task automatic queue_byte(logic [7:0] b, logic fresh, int row);
		body_q.push_back('{b, fresh, row});
		bytes_queued++;
	endtask

	task automatic wait_idle();
		while (bytes_taken != bytes_queued || due_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_code(logic [9:0] value);
		wait_idle();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Sender and receiver. Valid only drops after a request is taken or while already low.
	always @(negedge clk) begin
		if (arst_n) begin
			m_tready <= calm || ($urandom_range(99) >= 7);
			if (!s_tvalid || s_took) begin
				if (body_q.size() != 0 && (calm || $urandom_range(99) >= 7)) begin
					on_bus = body_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= on_bus.b;
					s_tuser <= on_bus.fresh;
					tagged_row <= on_bus.row;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			stall_cycles++;
			if (cfg_valid && cfg_ready) begin
				st_code = cfg_data;
				stall_cycles = 0;
			end
			if (m_tvalid && m_tready) begin
				stall_cycles = 0;
				got.phase = dpcsv_pkg::phase_t'(m_tdata[3:0]);
				got.pos = m_tdata[8:4];
				got.ch = m_tdata[16:9];
				got.year = m_tdata[31:17];
				got.month = m_tdata[39:32];
				got.day = m_tdata[46:40];
				got.volume = m_tdata[77:47];
				got.char_valid = m_tuser[0];
				got.field_end = m_tuser[1];
				if (due_results.size() == 0) begin
					$error("result with nothing expected: phase %0d", got.phase);
					fails++;
				end else begin
					want = due_results.pop_front();
					compare_field("phase", want.phase, got.phase);
					compare_field("price_char_valid", want.char_valid, got.char_valid);
					compare_field("price_pos", want.pos, got.pos);
					compare_field("price_char", want.ch, got.ch);
					compare_field("field_end", want.field_end, got.field_end);
					compare_field("year_since_1900", $signed(want.year), $signed(got.year));
					compare_field("month_index", $signed(want.month), $signed(got.month));
					compare_field("day_of_month", want.day, got.day);
					compare_field("volume", want.volume, got.volume);
				end
			end
			s_took = s_tvalid && s_tready;
			if (s_took) begin
				stall_cycles = 0;
				bytes_taken++;
				want = parse_byte(s_tdata, s_tuser[0]);
				if (tagged_row >= 0 && plan[tagged_row].typed) begin
					want.phase = plan[tagged_row].ph;
					want.year = 15'(plan[tagged_row].year);
					want.month = 8'(plan[tagged_row].month);
					want.day = 7'(plan[tagged_row].day);
					want.volume = 31'(plan[tagged_row].vol);
				end
				due_results.push_back(want);
			end
			if (stall_cycles >= StallLimit) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin : stimulus
		logic [7:0] body[$];
		logic [7:0] c;
		int         kind, r, n, f, k;
		bit         fresh;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (plan[i]) begin
			if (plan[i].code >= 0)
				write_code(10'(plan[i].code));
			if (plan[i].raw >= 0) begin
				queue_byte(8'(plan[i].raw), plan[i].fresh, i);
			end else begin
				n = plan[i].text.len();
				for (k = 0; k < n; k++)
					queue_byte(plan[i].text[k], plan[i].fresh && k == 0, (k == n - 1) ? i : -1);
			end
		end
		write_code(dpcsv_pkg::HTTP_OK);

		// Mostly complete responses with random content; some corrupted, some pure noise.
		while (bytes_queued < ByteTarget) begin
			if (st_code != dpcsv_pkg::HTTP_OK || $urandom_range(5) == 0) begin
				r = $urandom_range(9);
				write_code((r == 0) ? 10'd0 : (r == 1) ? 10'd999 :
					(r < 4) ? 10'($urandom_range(999)) : dpcsv_pkg::HTTP_OK);
			end
			calm = (bytes_queued >= 200 && bytes_queued < 330);
			body.delete();
			kind = $urandom_range(99);
			if (kind < 88) begin
				for (k = 0; k < dpcsv_pkg::HeaderLen; k++)
					body.push_back(hdr_text[k]);
				body.push_back(dpcsv_pkg::CH_NEWLINE);
				r = $urandom_range(9);
				n = (r == 0) ? 0 : (r < 3) ? $urandom_range(5, 6) : 4;
				repeat (n) body.push_back(8'h30 + 8'($urandom_range(9)));
				body.push_back(dpcsv_pkg::CH_DASH);
				repeat ($urandom_range(0, 3)) body.push_back(8'h30 + 8'($urandom_range(9)));
				body.push_back(dpcsv_pkg::CH_DASH);
				repeat ($urandom_range(0, 3)) body.push_back(8'h30 + 8'($urandom_range(9)));
				body.push_back(dpcsv_pkg::CH_COMMA);
				for (f = 0; f < 4; f++) begin
					r = $urandom_range(19);
					n = (r == 0) ? FieldMax : (r == 1) ? FieldMax + 1 : $urandom_range(0, 8);
					repeat (n) begin
						if ($urandom_range(5) == 0)
							body.push_back(dpcsv_pkg::CH_DOT);
						else
							body.push_back(8'h30 + 8'($urandom_range(9)));
					end
					body.push_back(dpcsv_pkg::CH_COMMA);
				end
				repeat ($urandom_range(0, 6)) begin
					do c = 8'($urandom_range(255)); while (c == dpcsv_pkg::CH_COMMA);
					body.push_back(c);
				end
				body.push_back(dpcsv_pkg::CH_COMMA);
				r = $urandom_range(9);
				n = (r == 0) ? 0 : (r == 1) ? $urandom_range(10, 12) : $urandom_range(1, 9);
				repeat (n) body.push_back(8'h30 + 8'($urandom_range(9)));
				body.push_back(dpcsv_pkg::CH_NEWLINE);
				repeat ($urandom_range(0, 2)) body.push_back(8'($urandom_range(255)));
				if (kind >= 70)
					body[$urandom_range(body.size() - 1)] = 8'($urandom_range(255));
			end else begin
				repeat ($urandom_range(1, 16)) body.push_back(8'($urandom_range(255)));
			end
			fresh = ($urandom_range(19) != 0);
			foreach (body[i])
				queue_byte(body[i], fresh && i == 0, -1);
			while (body_q.size() > 8)
				@(posedge clk);
		end
		calm = 1'b0;

		wait_idle();
		repeat (4) @(posedge clk);
		if (fails == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

FILE: daily_price_csv_parser.f
rtl/core/dpcsv_pkg.sv
rtl/core/dpcsv_step.sv
rtl/core/daily_price_csv_parser.sv
tb/testbench.sv
